@@ rtl/selective_repeat_receiver_core_defines.svh @@
// assertion macros shared by the receiver rtl
`ifndef SELECTIVE_REPEAT_RECEIVER_CORE_DEFINES_SVH
`define SELECTIVE_REPEAT_RECEIVER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define SRR_ASSERT_AT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("srr assertion failed");
`define SRR_ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("srr forbidden condition seen");
`else
`define SRR_ASSERT_AT(label, clk, rst_n, prop)
`define SRR_ASSERT_NEVER(label, clk, rst_n, cond)
`endif

`endif

@@ rtl/srr_pkg.sv @@
// shared constants, types and functions of the selective repeat receiver
package srr_pkg;

    localparam int unsigned SEQ_BITS      = 20;
    localparam int unsigned CHK_BITS      = 22;
    localparam int unsigned PAYLOAD_BYTES = 20;
    localparam int unsigned PAY_BITS      = 8 * PAYLOAD_BYTES;
    localparam int unsigned BSUM_BITS     = 13;
    localparam int unsigned WINDOW_DEF    = 10;

    localparam logic [SEQ_BITS-1:0] SEQ_TOP = '1;

    typedef enum logic {
        K_ACK     = 1'b0,
        K_DELIVER = 1'b1
    } t_kind;

    // sum of the payload bytes, at most 20 * 255
    function automatic logic [BSUM_BITS-1:0] byte_sum(input logic [PAY_BITS-1:0] pay);
        logic [BSUM_BITS-1:0] acc;
        acc = '0;
        for (int i = 0; i < PAYLOAD_BYTES; i++) begin
            acc = acc + BSUM_BITS'(pay[8*i +: 8]);
        end
        return acc;
    endfunction

endpackage

@@ rtl/srr_pkt_if.sv @@
// packet input channel: valid/ready with the packet fields
interface srr_pkt_if;
    import srr_pkg::*;

    logic                valid;
    logic                ready;
    logic [SEQ_BITS-1:0] seq_num;
    logic [SEQ_BITS-1:0] ack_num;
    logic [CHK_BITS-1:0] check_value;
    logic [63:0]         payload_low;
    logic [63:0]         payload_mid;
    logic [31:0]         payload_high;

    modport source (
        output valid, seq_num, ack_num, check_value, payload_low, payload_mid, payload_high,
        input  ready
    );
    modport sink (
        input  valid, seq_num, ack_num, check_value, payload_low, payload_mid, payload_high,
        output ready
    );
endinterface

@@ rtl/srr_res_if.sv @@
// result output channel: valid/ready with ack or delivery fields
interface srr_res_if;
    import srr_pkg::*;

    logic                valid;
    logic                ready;
    logic                kind;
    logic [SEQ_BITS-1:0] out_seq;
    logic [SEQ_BITS-1:0] out_ack;
    logic [CHK_BITS-1:0] out_check;
    logic [63:0]         out_payload_low;
    logic [63:0]         out_payload_mid;
    logic [31:0]         out_payload_high;
    logic                last;

    modport source (
        output valid, kind, out_seq, out_ack, out_check,
               out_payload_low, out_payload_mid, out_payload_high, last,
        input  ready
    );
    modport sink (
        input  valid, kind, out_seq, out_ack, out_check,
               out_payload_low, out_payload_mid, out_payload_high, last,
        output ready
    );
endinterface

@@ rtl/srr_ram.sv @@
// generic single-write, single-read ram with registered read data
module srr_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 4
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

@@ rtl/selective_repeat_receiver_core.sv @@
// selective repeat receiver: checksum, window check, ring store and in-order delivery
// the ack beat is registered in S_ACK after S_CHECK, once the output register is free;
// packets are taken only in S_IDLE; a dropped one then passes S_CHECK, an acked one S_ACK too;
// the first delivery follows S_ACK, each further one passes S_READ for the ram read of its slot
// reset (synchronous, active low) clears window base, ring start and all slot full bits;
// the payload ram is not cleared, only slots marked full are ever delivered
module selective_repeat_receiver_core #(
    parameter int unsigned WINDOW = srr_pkg::WINDOW_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    srr_pkt_if.sink   i_pkt,
    srr_res_if.source o_res
);
    import srr_pkg::*;
    `include "selective_repeat_receiver_core_defines.svh"

    localparam int unsigned IDX_W = $clog2(WINDOW);

    typedef enum logic [4:0] {
        S_IDLE    = 5'b00001,
        S_CHECK   = 5'b00010,
        S_ACK     = 5'b00100,
        S_READ    = 5'b01000,
        S_DELIVER = 5'b10000
    } t_state;

    t_state              r_state, n_state;
    logic [SEQ_BITS-1:0] r_base, n_base;
    logic [IDX_W-1:0]    r_ring, n_ring;
    logic [WINDOW-1:0]   r_full, n_full;
    logic                r_dup, n_dup;

    logic [SEQ_BITS-1:0]  r_seq, n_seq;
    logic [SEQ_BITS-1:0]  r_ack, n_ack;
    logic [CHK_BITS-1:0]  r_chk, n_chk;
    logic [PAY_BITS-1:0]  r_pay, n_pay;
    logic [BSUM_BITS-1:0] r_bsum, n_bsum;

    logic                r_o_valid, n_o_valid;
    t_kind               r_o_kind, n_o_kind;
    logic [SEQ_BITS-1:0] r_o_seq, n_o_seq;
    logic [SEQ_BITS-1:0] r_o_ack, n_o_ack;
    logic [CHK_BITS-1:0] r_o_check, n_o_check;
    logic [PAY_BITS-1:0] r_o_pay, n_o_pay;
    logic                r_o_last, n_o_last;

    logic                w_out_free;
    logic                w_accept;
    logic [CHK_BITS-1:0] w_sum;
    logic                w_csum_ok;
    logic [SEQ_BITS:0]   w_limit;
    logic                w_beyond;
    logic                w_below;
    logic [SEQ_BITS-1:0] w_diff;
    logic [IDX_W:0]      w_ring_sum;
    logic [IDX_W-1:0]    w_slot;
    logic [IDX_W-1:0]    w_ring_nx;
    logic                w_at_top;
    logic                w_last_dlv;
    logic                w_we;
    logic [PAY_BITS-1:0] w_rdata;
    logic [IDX_W:0]      w_ring_ext;

    srr_ram #(
        .WIDTH (PAY_BITS),
        .DEPTH (WINDOW)
    ) u_pay_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_slot),
        .i_wdata (r_pay),
        .i_raddr (r_ring),
        .o_rdata (w_rdata)
    );

    assign w_out_free = !r_o_valid || o_res.ready;
    assign i_pkt.ready = (r_state == S_IDLE);
    assign w_accept = i_pkt.valid && i_pkt.ready;

    // checksum and window position of the held packet
    assign w_sum = CHK_BITS'(r_bsum) + CHK_BITS'(r_seq) + CHK_BITS'(r_ack);
    assign w_csum_ok = (w_sum == r_chk);
    assign w_limit = {1'b0, r_base} + (SEQ_BITS+1)'(WINDOW);
    assign w_beyond = ({1'b0, r_seq} >= w_limit);
    assign w_below = (r_seq < r_base);
    assign w_diff = r_seq - r_base;
    assign w_ring_sum = {1'b0, r_ring} + {1'b0, w_diff[IDX_W-1:0]};
    assign w_slot = (w_ring_sum >= (IDX_W+1)'(WINDOW))
                    ? IDX_W'(w_ring_sum - (IDX_W+1)'(WINDOW))
                    : w_ring_sum[IDX_W-1:0];

    assign w_ring_nx = (r_ring == IDX_W'(WINDOW - 1)) ? '0 : r_ring + 1'b1;
    assign w_at_top = (r_base == SEQ_TOP);
    assign w_last_dlv = w_at_top || !r_full[w_ring_nx];
    assign w_ring_ext = {1'b0, r_ring};

    assign w_we = (r_state == S_CHECK) && w_csum_ok && !w_beyond && !w_below
                  && !r_full[w_slot];

    always_comb begin
        n_state   = r_state;
        n_base    = r_base;
        n_ring    = r_ring;
        n_full    = r_full;
        n_dup     = r_dup;
        n_seq     = r_seq;
        n_ack     = r_ack;
        n_chk     = r_chk;
        n_pay     = r_pay;
        n_bsum    = r_bsum;
        n_o_valid = r_o_valid && !o_res.ready;
        n_o_kind  = r_o_kind;
        n_o_seq   = r_o_seq;
        n_o_ack   = r_o_ack;
        n_o_check = r_o_check;
        n_o_pay   = r_o_pay;
        n_o_last  = r_o_last;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_seq   = i_pkt.seq_num;
                    n_ack   = i_pkt.ack_num;
                    n_chk   = i_pkt.check_value;
                    n_pay   = {i_pkt.payload_high, i_pkt.payload_mid, i_pkt.payload_low};
                    n_bsum  = byte_sum({i_pkt.payload_high, i_pkt.payload_mid,
                                        i_pkt.payload_low});
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (!w_csum_ok || w_beyond) begin
                    n_state = S_IDLE;
                end else begin
                    n_dup = w_below || r_full[w_slot];
                    if (w_we) begin
                        n_full[w_slot] = 1'b1;
                    end
                    n_state = S_ACK;
                end
            end
            S_ACK: begin
                if (w_out_free) begin
                    n_o_valid = 1'b1;
                    n_o_kind  = K_ACK;
                    n_o_seq   = r_seq;
                    n_o_ack   = r_seq;
                    n_o_check = CHK_BITS'(r_bsum) + CHK_BITS'({r_seq, 1'b0});
                    n_o_pay   = r_pay;
                    n_o_last  = r_dup || !r_full[r_ring];
                    n_state   = (r_dup || !r_full[r_ring]) ? S_IDLE : S_DELIVER;
                end
            end
            S_READ: begin
                // ram read of the new ring slot lands next cycle
                n_state = S_DELIVER;
            end
            S_DELIVER: begin
                if (w_out_free) begin
                    n_o_valid      = 1'b1;
                    n_o_kind       = K_DELIVER;
                    n_o_seq        = r_base;
                    n_o_ack        = '0;
                    n_o_check      = '0;
                    n_o_pay        = w_rdata;
                    n_o_last       = w_last_dlv;
                    n_full[r_ring] = 1'b0;
                    n_ring         = w_ring_nx;
                    // base saturates at the top of the sequence range
                    if (!w_at_top) begin
                        n_base = r_base + 1'b1;
                    end
                    n_state = w_last_dlv ? S_IDLE : S_READ;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_base    <= '0;
            r_ring    <= '0;
            r_full    <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_base    <= n_base;
            r_ring    <= n_ring;
            r_full    <= n_full;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dup     <= n_dup;
        r_seq     <= n_seq;
        r_ack     <= n_ack;
        r_chk     <= n_chk;
        r_pay     <= n_pay;
        r_bsum    <= n_bsum;
        r_o_kind  <= n_o_kind;
        r_o_seq   <= n_o_seq;
        r_o_ack   <= n_o_ack;
        r_o_check <= n_o_check;
        r_o_pay   <= n_o_pay;
        r_o_last  <= n_o_last;
    end

    assign o_res.valid            = r_o_valid;
    assign o_res.kind             = r_o_kind;
    assign o_res.out_seq          = r_o_seq;
    assign o_res.out_ack          = r_o_ack;
    assign o_res.out_check        = r_o_check;
    assign o_res.out_payload_low  = r_o_pay[63:0];
    assign o_res.out_payload_mid  = r_o_pay[127:64];
    assign o_res.out_payload_high = r_o_pay[159:128];
    assign o_res.last             = r_o_last;

    `SRR_ASSERT_AT(a_ring_range, i_clk, i_rst_n, w_ring_ext < (IDX_W+1)'(WINDOW))
    `SRR_ASSERT_AT(a_deliver_full, i_clk, i_rst_n, (r_state == S_DELIVER) |-> r_full[r_ring])
    `SRR_ASSERT_NEVER(a_idle_not_last, i_clk, i_rst_n, (r_state == S_IDLE) && r_o_valid && !r_o_last)
    `SRR_ASSERT_AT(a_base_step, i_clk, i_rst_n, (r_state == S_DELIVER) && w_out_free |=> (r_base == $past(r_base) + 1'b1) || (r_base == SEQ_TOP))
endmodule

@@ tb/sv/selective_repeat_receiver_checker.sv @@
// result checker for the selective repeat receiver: predicts acks and deliveries per packet beat
module selective_repeat_receiver_checker
    import srr_pkg::*;
#(
    parameter int unsigned WINDOW = WINDOW_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    srr_pkt_if   i_pkt,
    srr_res_if   i_res,
    output int   o_fail_count,
    output int   o_pending
);

    typedef struct {
        t_kind               kind;
        logic [SEQ_BITS-1:0] seq;
        logic [SEQ_BITS-1:0] ack;
        logic [CHK_BITS-1:0] chk;
        logic [63:0]         pay_low;
        logic [63:0]         pay_mid;
        logic [31:0]         pay_high;
        logic                last;
    } rx_result_t;

    logic [SEQ_BITS-1:0] win_base;
    int unsigned         ring_pos;
    bit                  slot_full [WINDOW];
    logic [63:0]         slot_low [WINDOW];
    logic [63:0]         slot_mid [WINDOW];
    logic [31:0]         slot_high [WINDOW];
    rx_result_t          rx_results_q [$];
    rx_result_t          head;

    function automatic int unsigned payload_byte_sum(input logic [63:0] lo,
                                                     input logic [63:0] mid,
                                                     input logic [31:0] hi);
        int unsigned acc;
        acc = 0;
        for (int i = 0; i < 8; i++) begin
            acc += lo[8*i +: 8];
            acc += mid[8*i +: 8];
        end
        for (int i = 0; i < 4; i++) begin
            acc += hi[8*i +: 8];
        end
        return acc;
    endfunction

    // works out the ack and the in-order deliveries that one packet causes
    task automatic receive_packet(input logic [SEQ_BITS-1:0] seq,
                                  input logic [SEQ_BITS-1:0] ack,
                                  input logic [CHK_BITS-1:0] chk,
                                  input logic [63:0] lo,
                                  input logic [63:0] mid,
                                  input logic [31:0] hi);
        int unsigned bsum;
        int unsigned s;
        int unsigned a;
        int unsigned b;
        int unsigned slot;
        rx_result_t  r;
        bsum = payload_byte_sum(lo, mid, hi);
        s = seq;
        a = ack;
        b = win_base;
        if (bsum + s + a != chk) return;
        // window limit is taken without wrap
        if (s >= b + WINDOW) return;

        r.kind     = K_ACK;
        r.seq      = seq;
        r.ack      = seq;
        r.chk      = CHK_BITS'(bsum + 2 * s);
        r.pay_low  = lo;
        r.pay_mid  = mid;
        r.pay_high = hi;
        r.last     = 1'b1;
        if (s < b) begin
            rx_results_q.push_back(r);
            return;
        end
        slot = (ring_pos + (s - b)) % WINDOW;
        if (slot_full[slot]) begin
            rx_results_q.push_back(r);
            return;
        end

        slot_full[slot] = 1'b1;
        slot_low[slot]  = lo;
        slot_mid[slot]  = mid;
        slot_high[slot] = hi;
        r.last = 1'b0;
        rx_results_q.push_back(r);

        for (int n = 0; n < WINDOW; n++) begin
            if (!slot_full[ring_pos]) break;
            r.kind     = K_DELIVER;
            r.seq      = win_base;
            r.ack      = '0;
            r.chk      = '0;
            r.pay_low  = slot_low[ring_pos];
            r.pay_mid  = slot_mid[ring_pos];
            r.pay_high = slot_high[ring_pos];
            rx_results_q.push_back(r);
            slot_full[ring_pos] = 1'b0;
            ring_pos = (ring_pos + 1) % WINDOW;
            // base saturates at the top sequence number and ends the burst
            if (win_base == SEQ_TOP) break;
            win_base++;
        end
        rx_results_q[rx_results_q.size() - 1].last = 1'b1;
    endtask

    task automatic compare_field(input string name, input logic [63:0] want,
                                 input logic [63:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
            o_fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            win_base = '0;
            ring_pos = 0;
            foreach (slot_full[i]) slot_full[i] = 1'b0;
            rx_results_q.delete();
            o_fail_count = 0;
        end else begin
            // result beat first: it cannot stem from a packet taken at this edge
            if (i_res.valid && i_res.ready) begin
                if (rx_results_q.size() == 0) begin
                    $display("%0t: unexpected result beat, expected none actual seq %h",
                             $time, i_res.out_seq);
                    o_fail_count++;
                end else begin
                    head = rx_results_q.pop_front();
                    compare_field("kind", head.kind, i_res.kind);
                    compare_field("out_seq", head.seq, i_res.out_seq);
                    compare_field("out_ack", head.ack, i_res.out_ack);
                    compare_field("out_check", head.chk, i_res.out_check);
                    compare_field("out_payload_low", head.pay_low, i_res.out_payload_low);
                    compare_field("out_payload_mid", head.pay_mid, i_res.out_payload_mid);
                    compare_field("out_payload_high", head.pay_high, i_res.out_payload_high);
                    compare_field("last", head.last, i_res.last);
                end
            end
            if (i_pkt.valid && i_pkt.ready) begin
                receive_packet(i_pkt.seq_num, i_pkt.ack_num, i_pkt.check_value,
                               i_pkt.payload_low, i_pkt.payload_mid, i_pkt.payload_high);
            end
        end
        o_pending = rx_results_q.size();
    end

endmodule

@@ tb/sv/selective_repeat_receiver_core_tb.sv @@
// testbench top for the selective repeat receiver: clock, reset, packet stimulus and verdict
module selective_repeat_receiver_core_tb;
    import srr_pkg::*;

    localparam int unsigned WINDOW = WINDOW_DEF;

    logic i_clk = 1'b0;
    logic i_rst_n;

    srr_pkt_if pkt_bus ();
    srr_res_if res_bus ();

    int          fail_count;
    int          pending;
    bit          no_idle;
    // sender's own view of the window base, from the good packets it sent
    int unsigned tx_base;
    bit          seq_sent [0:4095];

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    selective_repeat_receiver_core #(
        .WINDOW(WINDOW)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_pkt  (pkt_bus),
        .o_res  (res_bus)
    );

    selective_repeat_receiver_checker #(
        .WINDOW(WINDOW)
    ) rx_check (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pkt       (pkt_bus),
        .i_res       (res_bus),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    function automatic int unsigned packet_byte_sum(input logic [63:0] lo,
                                                    input logic [63:0] mid,
                                                    input logic [31:0] hi);
        int unsigned acc;
        acc = 0;
        for (int i = 0; i < 8; i++) begin
            acc += lo[8*i +: 8] + mid[8*i +: 8];
        end
        for (int i = 0; i < 4; i++) begin
            acc += hi[8*i +: 8];
        end
        return acc;
    endfunction

    function automatic logic [63:0] rand_word();
        case ($urandom_range(9))
            0: return '0;
            1: return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic send_pkt(input logic [SEQ_BITS-1:0] seq, input logic [SEQ_BITS-1:0] ack,
                            input logic [CHK_BITS-1:0] chk, input logic [63:0] lo,
                            input logic [63:0] mid, input logic [31:0] hi);
        while (!no_idle && $urandom_range(99) < 19) begin
            pkt_bus.valid <= 1'b0;
            @(negedge i_clk);
        end
        pkt_bus.valid        <= 1'b1;
        pkt_bus.seq_num      <= seq;
        pkt_bus.ack_num      <= ack;
        pkt_bus.check_value  <= chk;
        pkt_bus.payload_low  <= lo;
        pkt_bus.payload_mid  <= mid;
        pkt_bus.payload_high <= hi;
        @(posedge i_clk);
        while (!pkt_bus.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // packet with a correct checksum
    task automatic send_good(input logic [SEQ_BITS-1:0] seq, input logic [SEQ_BITS-1:0] ack,
                             input logic [63:0] lo, input logic [63:0] mid,
                             input logic [31:0] hi);
        int unsigned s;
        s = seq;
        send_pkt(seq, ack, CHK_BITS'(packet_byte_sum(lo, mid, hi) + s + ack), lo, mid, hi);
        if (s >= tx_base && s < tx_base + WINDOW) seq_sent[s] = 1'b1;
        while (seq_sent[tx_base]) tx_base++;
    endtask

    // packet whose checksum is off by a nonzero amount
    task automatic send_bad(input logic [SEQ_BITS-1:0] seq, input logic [SEQ_BITS-1:0] ack,
                            input logic [CHK_BITS-1:0] delta, input logic [63:0] lo,
                            input logic [63:0] mid, input logic [31:0] hi);
        send_pkt(seq, ack, CHK_BITS'(packet_byte_sum(lo, mid, hi) + seq + ack + delta),
                 lo, mid, hi);
    endtask

    task automatic drain_results(input int settle);
        pkt_bus.valid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        repeat (settle) @(negedge i_clk);
    endtask

    initial begin
        res_bus.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            res_bus.ready <= no_idle || ($urandom_range(99) >= 19);
        end
    end

    initial begin
        int unsigned            pick;
        int unsigned            back;
        logic [SEQ_BITS-1:0]    seq;
        logic [SEQ_BITS-1:0]    ack;
        logic [CHK_BITS-1:0]    delta;
        logic [63:0]            lo;
        logic [63:0]            mid;
        logic [31:0]            hi;

        i_rst_n              = 1'b0;
        pkt_bus.valid        = 1'b0;
        pkt_bus.seq_num      = '0;
        pkt_bus.ack_num      = '0;
        pkt_bus.check_value  = '0;
        pkt_bus.payload_low  = '0;
        pkt_bus.payload_mid  = '0;
        pkt_bus.payload_high = '0;
        no_idle              = 1'b0;
        tx_base              = 0;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // in-order packet with an empty payload: ack then delivery
        send_good(0, 0, '0, '0, '0);
        // duplicate below the base, all-ones payload and ack number
        send_good(0, '1, '1, '1, '1);
        // bad checksums, one off by one and one at the checksum maximum
        send_bad(1, 20'h00042, 1, rand_word(), rand_word(), 32'(rand_word()));
        send_bad('1, '1, 22'h200001, '0, '0, '0);
        // beyond the window: far away and just past the edge
        send_good('1, 20'h12345, rand_word(), rand_word(), 32'(rand_word()));
        send_good(11, SEQ_BITS'($urandom), rand_word(), rand_word(), 32'(rand_word()));
        // last slot of the window, then a duplicate of a full slot
        send_good(10, SEQ_BITS'($urandom), rand_word(), rand_word(), 32'(rand_word()));
        send_good(10, SEQ_BITS'($urandom), rand_word(), rand_word(), 32'(rand_word()));
        // fill the gap backwards so the final packet drains the whole window
        for (int s = 9; s >= 1; s--) begin
            send_good(SEQ_BITS'(s), SEQ_BITS'($urandom), rand_word(), rand_word(),
                      32'(rand_word()));
        end
        // large ack number pushes the packet checksum past 20 bits
        send_good(11, '1, '1, '1, '1);
        drain_results(0);

        // base saturation at the top sequence number lies beyond a run of this length
        for (int i = 0; i < 140; i++) begin
            no_idle = (i >= 60 && i < 100);
            if (i % 45 == 44) drain_results(4);
            pick = $urandom_range(99);
            lo   = rand_word();
            mid  = rand_word();
            hi   = 32'(rand_word());
            ack  = SEQ_BITS'($urandom);
            if (pick < 55 || (pick < 67 && tx_base == 0)) begin
                send_good(SEQ_BITS'(tx_base + $urandom_range(WINDOW - 1)), ack, lo, mid, hi);
            end else if (pick < 67) begin
                back = (tx_base < 8) ? tx_base : 8;
                send_good(SEQ_BITS'(tx_base - $urandom_range(1, back)), ack, lo, mid, hi);
            end else if (pick < 77) begin
                if ($urandom_range(1)) seq = SEQ_BITS'(tx_base + WINDOW + $urandom_range(5));
                else seq = SEQ_BITS'($urandom);
                send_good(seq, ack, lo, mid, hi);
            end else begin
                if ($urandom_range(1)) seq = SEQ_BITS'(tx_base + $urandom_range(WINDOW - 1));
                else seq = SEQ_BITS'($urandom);
                if ($urandom_range(1)) delta = CHK_BITS'($urandom_range(1, 3));
                else delta = CHK_BITS'($urandom_range(1, 22'h3FFFFF));
                send_bad(seq, ack, delta, lo, mid, hi);
            end
        end
        no_idle = 1'b0;
        drain_results(40);

        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
